FILE: rtl/core/jsu_pkg.sv
// jsu_pkg: shared types, codes and helper functions for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8.
// No dependencies.
`default_nettype none

package jsu_pkg;

  // decoder modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_HEX  = 3'd3;
  localparam logic [2:0] MODE_PBS  = 3'd4;
  localparam logic [2:0] MODE_PU   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_HEX    = 3'd0;
  localparam logic [2:0] ERR_LONE   = 3'd1;
  localparam logic [2:0] ERR_MISS   = 3'd2;
  localparam logic [2:0] ERR_LOW    = 3'd3;
  localparam logic [2:0] ERR_UNTERM = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // surrogate bounds
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // one decoded input byte: up to four results, cnt holds count minus one
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0]      err;
    logic [3:0][7:0] bytes;
  } jsu_job_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic jsu_job_t encode_utf8(input logic [20:0] cp);
    jsu_job_t j;
    j = '0;
    j.kind = KIND_DATA;
    if (cp <= 21'h7F) begin
      j.cnt      = 2'd0;
      j.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      j.cnt      = 2'd1;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      j.cnt      = 2'd2;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      j.cnt      = 2'd3;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

  function automatic jsu_job_t single(input logic [1:0] kind, input logic [7:0] b,
                                      input logic [2:0] err);
    jsu_job_t j;
    j = '0;
    j.kind     = kind;
    j.bytes[0] = b;
    j.err      = err;
    return j;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jsu_front.sv
// jsu_front: byte classifier and escape decoder; turns each accepted byte into a job.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic     q_full,
  output logic          q_push,
  output jsu_job_t      q_job
);

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        pair_r, pair_nxt;

  logic        acc;
  logic        emit;
  jsu_job_t    job;
  logic [4:0]  hd;
  logic [15:0] cp16;
  logic        in_str;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign hd        = hex_digit(in_tdata);
  assign cp16      = {hex_r[11:0], hd[3:0]};
  assign in_str    = (mode_r >= MODE_STR) && (mode_r <= MODE_PU);

  always_comb begin
    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    dcnt_nxt = dcnt_r;
    high_nxt = high_r;
    pair_nxt = pair_r;
    emit     = 1'b0;
    job      = '0;
    if (in_str && in_tdata == CH_NUL) begin
      mode_nxt = MODE_IDLE; pair_nxt = 1'b0; dcnt_nxt = 2'd0;
      emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_UNTERM);
    end else begin
      case (mode_r)
        MODE_STR: begin
          if (in_tdata == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            emit = 1'b1; job = single(KIND_END, 8'h00, ERR_HEX);
          end else if (in_tdata == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            emit = 1'b1; job = single(KIND_DATA, in_tdata, ERR_HEX);
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_STR;
          case (in_tdata)
            CH_BSLASH, CH_QUOTE, CH_SLASH: begin
              emit = 1'b1; job = single(KIND_DATA, in_tdata, ERR_HEX);
            end
            CH_B: begin emit = 1'b1; job = single(KIND_DATA, 8'h08, ERR_HEX); end
            CH_F: begin emit = 1'b1; job = single(KIND_DATA, 8'h0C, ERR_HEX); end
            CH_N: begin emit = 1'b1; job = single(KIND_DATA, 8'h0A, ERR_HEX); end
            CH_R: begin emit = 1'b1; job = single(KIND_DATA, 8'h0D, ERR_HEX); end
            CH_T: begin emit = 1'b1; job = single(KIND_DATA, 8'h09, ERR_HEX); end
            CH_U: begin
              mode_nxt = MODE_HEX; hex_nxt = 16'h0; dcnt_nxt = 2'd0; pair_nxt = 1'b0;
            end
            default: ;
          endcase
        end
        MODE_HEX: begin
          if (!hd[4]) begin
            mode_nxt = MODE_IDLE; pair_nxt = 1'b0; dcnt_nxt = 2'd0;
            emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_HEX);
          end else begin
            hex_nxt = cp16;
            if (dcnt_r == 2'd3) begin
              dcnt_nxt = 2'd0;
              if (pair_r) begin
                pair_nxt = 1'b0;
                if (cp16 < LO_SUR_MIN || cp16 > LO_SUR_MAX) begin
                  mode_nxt = MODE_IDLE;
                  emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_LOW);
                end else begin
                  mode_nxt = MODE_STR;
                  emit = 1'b1; job = encode_utf8(SUPP_BASE + {1'b0, high_r, cp16[9:0]});
                end
              end else if (cp16 >= HI_SUR_MIN && cp16 <= HI_SUR_MAX) begin
                high_nxt = cp16[9:0];
                mode_nxt = MODE_PBS;
              end else if (cp16 >= LO_SUR_MIN && cp16 <= LO_SUR_MAX) begin
                mode_nxt = MODE_IDLE;
                emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_LONE);
              end else begin
                mode_nxt = MODE_STR;
                emit = 1'b1; job = encode_utf8({5'd0, cp16});
              end
            end else begin
              dcnt_nxt = dcnt_r + 2'd1;
            end
          end
        end
        MODE_PBS: begin
          if (in_tdata != CH_BSLASH) begin
            mode_nxt = MODE_IDLE; pair_nxt = 1'b0; dcnt_nxt = 2'd0;
            emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_MISS);
          end else begin
            mode_nxt = MODE_PU;
          end
        end
        MODE_PU: begin
          if (in_tdata != CH_U) begin
            mode_nxt = MODE_IDLE; pair_nxt = 1'b0; dcnt_nxt = 2'd0;
            emit = 1'b1; job = single(KIND_ERR, 8'h00, ERR_MISS);
          end else begin
            mode_nxt = MODE_HEX; hex_nxt = 16'h0; dcnt_nxt = 2'd0; pair_nxt = 1'b1;
          end
        end
        default: begin
          mode_nxt = (in_tdata == CH_QUOTE) ? MODE_STR : MODE_IDLE;
        end
      endcase
    end
  end

  assign q_push = acc && emit;
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hex_r  <= 16'h0;
      dcnt_r <= 2'd0;
      high_r <= 10'h0;
      pair_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      dcnt_r <= dcnt_nxt;
      high_r <= high_nxt;
      pair_r <= pair_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/jsu_queue.sv
// jsu_queue: short job queue between the decoder front and the result serialiser.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire jsu_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output jsu_job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_job_t         slots_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slots_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    if (do_pop)  rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_r] <= push_job;
  end

endmodule

`default_nettype wire

FILE: rtl/core/jsu_back.sv
// jsu_back: serialises queued jobs into result beats, one per cycle while out_tready is high, tlast on the final one.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire jsu_job_t q_job,
  output logic          q_pop,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [15:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);

  jsu_job_t   job_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       take, final_beat, load;

  assign take       = busy_r && out_tready;
  assign final_beat = (idx_r == job_r.cnt);
  assign load       = q_valid && (!busy_r || (take && final_beat));
  assign q_pop      = load;

  assign out_tvalid = busy_r;
  assign out_tuser  = job_r.kind;
  assign out_tdata  = {5'd0, job_r.err, job_r.bytes[idx_r]};
  assign out_tlast  = final_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (take) begin
      if (final_beat) busy_r <= 1'b0;
      else            idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= q_job;
  end

endmodule

`default_nettype wire

FILE: rtl/core/json_string_unescape_utf8.sv
// json_string_unescape_utf8: byte-serial JSON string unescaper with UTF-8 output.
// Path: an accepted byte's job is registered in the job queue, then in the output stage.
// Throughput: one input byte per cycle while the job queue is not full; one result beat per
// cycle while out_tready is high; a \u escape giving four UTF-8 bytes is absorbed by the job queue.
// Reset: rst_n synchronous, active low; clears decoder mode, queue and output stage.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
`default_nettype none

module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data_byte, [10:8] err_code, rest zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);

  // Front: decode each accepted byte into a job of one to four results, or into none.
  // A byte that gives no result pushes nothing.
  logic     q_push, q_full, q_pop, q_valid;
  jsu_job_t q_in_job, q_head_job;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  // Queue: decouple the decoder from the output so either side may stall.
  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  // Back: hold one job in the output register and advance one beat per transfer.
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // End markers and errors are always single, final beats.
  a_single_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_DATA) |-> out_tlast)
    else $error("end or error beat without tlast");

  // Only the three defined kinds ever leave the block.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_DATA || out_tuser == KIND_END ||
                    out_tuser == KIND_ERR))
    else $error("undefined result kind");

  // A push never lands on a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

`default_nettype wire

FILE: tb/json_string_unescape_utf8_test.sv
// Self-checking bench for json_string_unescape_utf8: drives byte beats, predicts every
// result beat with an in-bench decoder and compares them in order.
// Depends on jsu_pkg (codes, characters, surrogate bounds) and the block itself.
`default_nettype none

module json_string_unescape_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int          DRAIN_CYCLES   = 16;        // drain slack after the last awaited beat
  localparam int          HOLDOFF_CYCLES = 250;       // long output stall, fills the job queue
  localparam int          RANDOM_BYTES   = 340;
  localparam int          TIMEOUT_NS     = 2_400_000; // far beyond a slow run
  localparam logic [2:0]  NO_ERR         = 3'd0;      // err field outside error beats

  // one expected result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       is_last;
  } unesc_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] data_byte, [10:8] err_code, rest zero
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        out_tlast;

  json_string_unescape_utf8 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder prediction: the bench's own copy of the unescaper state
  // ---------------------------------------------------------------------------
  logic [2:0]  dec_mode = MODE_IDLE;
  logic [15:0] hex_acc = 16'h0000;
  logic [1:0]  digit_cnt = 2'd0;
  logic [9:0]  high_half = 10'd0;
  logic        want_low_half = 1'b0;   // the \u being collected is the low half of a pair

  unesc_beat_t decoded_beats[$];       // beats produced by the byte being decoded
  unesc_beat_t awaited_beats[$];       // beats the block still owes, oldest first

  task automatic emit(input logic [1:0] kind, input logic [7:0] data, input logic [2:0] err);
    decoded_beats.push_back('{kind, data, err, 1'b0});
  endtask

  // every error drops the string and returns to idle
  task automatic abort_string(input logic [2:0] code);
    dec_mode      = MODE_IDLE;
    want_low_half = 1'b0;
    digit_cnt     = 2'd0;
    emit(KIND_ERR, 8'h00, code);
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(KIND_DATA, cp[7:0], NO_ERR);
    end else if (cp <= 21'h7FF) begin
      emit(KIND_DATA, 8'hC0 | cp[10:6], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[5:0], NO_ERR);
    end else if (cp <= 21'hFFFF) begin
      emit(KIND_DATA, 8'hE0 | cp[15:12], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[11:6], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[5:0], NO_ERR);
    end else begin
      emit(KIND_DATA, 8'hF0 | cp[20:18], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[17:12], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[11:6], NO_ERR);
      emit(KIND_DATA, 8'h80 | cp[5:0], NO_ERR);
    end
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    return -1;
  endfunction

  // fourth hex digit seen: resolve the escape, holding a high surrogate for its partner
  task automatic resolve_escape();
    logic [15:0] cp;
    cp = hex_acc;
    if (want_low_half) begin
      want_low_half = 1'b0;
      if (cp < LO_SUR_MIN || cp > LO_SUR_MAX) begin
        abort_string(ERR_LOW);
      end else begin
        dec_mode = MODE_STR;
        emit_code_point(SUPP_BASE + {high_half, cp[9:0]});
      end
    end else if (cp >= HI_SUR_MIN && cp <= HI_SUR_MAX) begin
      high_half = cp[9:0];
      dec_mode  = MODE_PBS;
    end else if (cp >= LO_SUR_MIN && cp <= LO_SUR_MAX) begin
      abort_string(ERR_LONE);
    end else begin
      dec_mode = MODE_STR;
      emit_code_point({5'd0, cp});
    end
  endtask

  // decode one accepted byte and queue the beats it must produce
  task automatic predict_byte(input logic [7:0] c);
    int          nib;
    unesc_beat_t b;
    decoded_beats.delete();
    if (dec_mode >= MODE_STR && dec_mode <= MODE_PU && c == CH_NUL) begin
      abort_string(ERR_UNTERM);
    end else begin
      case (dec_mode)
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            dec_mode = MODE_IDLE;
            emit(KIND_END, 8'h00, NO_ERR);
          end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            emit(KIND_DATA, c, NO_ERR);
          end
        end
        MODE_ESC: begin
          dec_mode = MODE_STR;
          case (c)
            CH_BSLASH, CH_QUOTE, CH_SLASH: emit(KIND_DATA, c, NO_ERR);
            CH_B: emit(KIND_DATA, 8'h08, NO_ERR);
            CH_F: emit(KIND_DATA, 8'h0C, NO_ERR);
            CH_N: emit(KIND_DATA, 8'h0A, NO_ERR);
            CH_R: emit(KIND_DATA, 8'h0D, NO_ERR);
            CH_T: emit(KIND_DATA, 8'h09, NO_ERR);
            CH_U: begin
              dec_mode      = MODE_HEX;
              hex_acc       = 16'h0000;
              digit_cnt     = 2'd0;
              want_low_half = 1'b0;
            end
            default: ;  // unknown escape: drop it silently
          endcase
        end
        MODE_HEX: begin
          nib = hex_nibble(c);
          if (nib < 0) begin
            abort_string(ERR_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (digit_cnt == 2'd3) begin
              digit_cnt = 2'd0;
              resolve_escape();
            end else begin
              digit_cnt = digit_cnt + 2'd1;
            end
          end
        end
        MODE_PBS: begin
          if (c != CH_BSLASH) abort_string(ERR_MISS);
          else dec_mode = MODE_PU;
        end
        MODE_PU: begin
          if (c != CH_U) begin
            abort_string(ERR_MISS);
          end else begin
            dec_mode      = MODE_HEX;
            hex_acc       = 16'h0000;
            digit_cnt     = 2'd0;
            want_low_half = 1'b1;
          end
        end
        default: dec_mode = (c == CH_QUOTE) ? MODE_STR : MODE_IDLE;
      endcase
    end
    // only the final beat of this byte carries tlast
    foreach (decoded_beats[i]) begin
      b         = decoded_beats[i];
      b.is_last = (i == decoded_beats.size() - 1);
      awaited_beats.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  logic [7:0] text_bytes[$];   // bytes still to be offered on the input
  int         strings_built = 0;

  task automatic push(input logic [7:0] b);
    text_bytes.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push(s[i]);
  endtask

  // hex digit in either case, so both letter ranges get exercised
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic add_u(input logic [15:0] v);
    push(CH_BSLASH);
    push(CH_U);
    for (int i = 3; i >= 0; i--) push(hex_char(v[i*4 +: 4]));
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] simple_escape(input int idx);
    case (idx)
      0: return CH_BSLASH;
      1: return CH_QUOTE;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] odd_escape();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b inside {CH_BSLASH, CH_QUOTE, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (hex_nibble(b) >= 0);
    return b;
  endfunction

  // non-surrogate code unit, spread over the one, two and three byte encodings
  function automatic logic [15:0] bmp_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] high_sur();
    return 16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX));
  endfunction

  // end a string on one of the error paths
  task automatic add_broken_tail();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: begin
        push(CH_BSLASH);
        push(CH_U);
        repeat ($urandom_range(0, 3)) push(hex_char(4'($urandom_range(0, 15))));
        push(non_hex());
      end
      1: add_u(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
      2: begin
        add_u(high_sur());
        if ($urandom_range(0, 1)) begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_BSLASH);
          push(b);
        end else begin
          push(CH_BSLASH);
          do b = 8'($urandom_range(1, 255)); while (b == CH_U);
          push(b);
        end
      end
      3: begin
        // high half followed by a second escape that is not a low half
        add_u(high_sur());
        add_u($urandom_range(0, 1) ? bmp_value() : high_sur());
      end
      default: begin
        case ($urandom_range(0, 3))
          0: ;
          1: push(CH_BSLASH);
          2: begin
            push(CH_BSLASH);
            push(CH_U);
            repeat ($urandom_range(0, 3)) push(hex_char(4'($urandom_range(0, 15))));
          end
          default: begin
            add_u(high_sur());
            if ($urandom_range(0, 1)) push(CH_BSLASH);
          end
        endcase
        push(CH_NUL);
      end
    endcase
  endtask

  task automatic add_random_string();
    int pick;
    strings_built++;
    push(CH_QUOTE);
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push(plain_char());
      end else if (pick < 50) begin
        push(CH_BSLASH);
        push(simple_escape($urandom_range(0, 7)));
      end else if (pick < 55) begin
        push(CH_BSLASH);
        push(odd_escape());
      end else if (pick < 75) begin
        add_u(bmp_value());
      end else if (pick < 90) begin
        add_u(high_sur());
        add_u(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
      end else begin
        add_broken_tail();
        return;
      end
    end
    if ($urandom_range(0, 19) == 0) push(CH_NUL);
    else push(CH_QUOTE);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  logic in_beat_taken = 1'b0;   // input handshake completed at the last rising edge
  int   burst_left = 0;
  int   gap_left = 0;
  int   bytes_taken = 0;

  always @(negedge clk) begin
    logic       next_valid;
    logic [7:0] next_data;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_tvalid || in_beat_taken) begin
      // current beat gone: either sit out the gap or offer the next byte
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (text_bytes.size() > 0) begin
        next_data  = text_bytes.pop_front();
        next_valid = 1'b1;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          burst_left--;
        end
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // ---------------------------------------------------------------------------
  // Output ready: changing stall styles plus long hold-offs counted here
  // ---------------------------------------------------------------------------
  int holdoff_left = 0;
  int holdoffs_done = 0;
  int holdoff_at = 120;     // accepted-byte count that triggers the next hold-off
  int ready_style = 0;
  int style_left = 0;

  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (holdoffs_done < 2 && bytes_taken >= holdoff_at) begin
        // hold off while the sender keeps offering, so the block backs up
        holdoff_left = HOLDOFF_CYCLES - 1;
        holdoffs_done++;
        holdoff_at += 200;
      end else begin
        if (style_left == 0) begin
          ready_style = $urandom_range(0, 3);
          style_left  = $urandom_range(16, 80);
        end else begin
          style_left--;
        end
        case (ready_style)
          0: next_ready = 1'b1;                          // no stalls at all
          1: next_ready = 1'($urandom_range(0, 1));
          2: next_ready = ($urandom_range(0, 3) == 0);   // mostly stalled
          default: next_ready = (style_left % 5) < 3;    // periodic pattern, ready three fifths of the time
        endcase
      end
    end
    out_tready <= next_ready;
  end

  // ---------------------------------------------------------------------------
  // Prediction and checking at the rising edge
  // ---------------------------------------------------------------------------
  int mismatches = 0;
  int beats_checked = 0;
  int kind_seen[3] = '{0, 0, 0};

  task automatic note_mismatch(input string what);
    if (mismatches < 10) $display("[%0t] MISMATCH %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    unesc_beat_t want;
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_tvalid && in_tready;
      // predict before checking: a byte's beats never leave at its own edge
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata);
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (awaited_beats.size() == 0) begin
          note_mismatch($sformatf("unexpected beat kind=%0d tdata=%h tlast=%b",
                                  out_tuser, out_tdata, out_tlast));
        end else begin
          want = awaited_beats.pop_front();
          beats_checked++;
          if (want.kind <= KIND_ERR) kind_seen[want.kind]++;
          if (out_tuser !== want.kind || out_tdata !== {5'd0, want.err, want.data} ||
              out_tlast !== want.is_last)
            note_mismatch($sformatf(
              "beat %0d: expected kind=%0d data=%h err=%0d last=%b, got kind=%0d tdata=%h last=%b",
              beats_checked, want.kind, want.data, want.err, want.is_last,
              out_tuser, out_tdata, out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the byte stream, reset, run, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    int directed_len;

    // idle bytes (letters, NUL, top bit) are ignored before the opening quote
    push(8'h78);
    push(CH_NUL);
    push(8'hFF);
    // plain bytes at the extremes, every simple escape and an unknown one
    add_text("\"A");
    push(8'hFF);
    push(8'h01);
    add_text("\\\\\\\"\\/\\b\\f\\n\\r\\t\\q");
    // escaped NUL, UTF-8 length boundaries and the largest supplementary point
    add_text("\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uE000");
    add_text("\\uD800\\uDC00\\uDBFF\\uDFFF\"");
    add_text("\"\\u12G");             // bad hex digit
    add_text("\"\\uDC00");            // lone low surrogate
    add_text("\"\\uD83Dx");           // high surrogate not followed by a backslash
    add_text("\"\\uD83D\\x");         // backslash but no u
    add_text("\"\\uD83D\\u0041");     // second half not a low surrogate
    add_text("\"ab");                 // NUL inside plain text
    push(CH_NUL);
    add_text("\"\\");                 // NUL after backslash
    push(CH_NUL);
    add_text("\"\\u1");               // NUL among hex digits
    push(CH_NUL);
    add_text("\"\\uD800\\");          // NUL between the halves of a pair
    push(CH_NUL);
    directed_len  = text_bytes.size();
    strings_built = 10;

    // random strings with idle noise, including NUL and high bytes, between them
    while (text_bytes.size() < directed_len + RANDOM_BYTES) begin
      repeat ($urandom_range(0, 2)) begin
        logic [7:0] noise;
        do noise = 8'($urandom_range(0, 255)); while (noise == CH_QUOTE);
        push(noise);
      end
      add_random_string();
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (text_bytes.size() > 0 || in_tvalid) @(posedge clk);
    while (awaited_beats.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats in %0d strings, %0d output hold-offs.",
             bytes_taken, strings_built, holdoffs_done);
    $display("Checked %0d result beats: %0d data, %0d string ends, %0d errors.",
             beats_checked, kind_seen[KIND_DATA], kind_seen[KIND_END], kind_seen[KIND_ERR]);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d beats still awaited", awaited_beats.size());
    $display("json_string_unescape_utf8 verification failed");
    $finish;
  end

endmodule

`default_nettype wire
